// ----- hdl/otsc_pkg.sv -----
package otsc_pkg;

  localparam int SCRATCH_BYTES = 9;
  localparam int IDX_W         = $clog2(SCRATCH_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCRATCH_BYTES - 1);

  // scratchpad byte positions that are kept
  localparam logic [IDX_W-1:0] IDX_TEMP_LO = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_TEMP_HI = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_CONFIG  = IDX_W'(4);
  localparam logic [IDX_W-1:0] IDX_REMAIN  = IDX_W'(6);

  localparam logic [7:0] FAM_EXT   = 8'h10;
  localparam logic [7:0] FAM_RES_A = 8'h28;
  localparam logic [7:0] FAM_RES_B = 8'h22;

  localparam int TEMP_W = 12;
  localparam int T_MIN  = -550;
  localparam int T_MAX  = 1250;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CRC   = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic             accept;
    logic [IDX_W-1:0] idx;
    logic             norm;
    logic             scale;
    logic             load;
  } cmd_t;

endpackage

// ----- hdl/otsc_if.sv -----
interface otsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] scratch_byte;
  logic [7:0] family_code;
  logic       restart;

  modport source (output valid, scratch_byte, family_code, restart, input ready);
  modport sink (input valid, scratch_byte, family_code, restart, output ready);
endinterface

interface otsc_out_if;
  import otsc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature;
  logic [1:0]               status;

  modport source (output valid, temperature, status, input ready);
  modport sink (input valid, temperature, status, output ready);
endinterface

// ----- hdl/otsc_ctrl.sv -----
module otsc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_restart,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  output otsc_pkg::cmd_t cmd
);
  import otsc_pkg::*;

  typedef enum logic [1:0] {S_COLLECT, S_NORM, S_SCALE, S_CHECK} state_t;

  state_t           state;
  logic [IDX_W-1:0] cnt;
  logic [IDX_W-1:0] idx;
  logic             accept;
  logic             slot_free;

  assign in_ready  = (state == S_COLLECT);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign idx       = (in_restart || cnt >= IDX_W'(SCRATCH_BYTES)) ? '0 : cnt;

  assign cmd.accept = accept;
  assign cmd.idx    = idx;
  assign cmd.norm   = (state == S_NORM);
  assign cmd.scale  = (state == S_SCALE);
  assign cmd.load   = (state == S_CHECK) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_COLLECT;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new result beat replaces the one taken in the same cycle
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_COLLECT: begin
          if (accept) begin
            if (idx == LAST_IDX) begin
              cnt   <= '0;
              state <= S_NORM;
            end else begin
              cnt <= idx + IDX_W'(1);
            end
          end
        end
        S_NORM:  state <= S_SCALE;
        S_SCALE: state <= S_CHECK;
        S_CHECK: begin
          if (slot_free) begin
            state <= S_COLLECT;
          end
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_last_starts_conv: assert property (@(posedge clk) disable iff (rst)
    accept && idx == LAST_IDX |=> state == S_NORM && cnt == '0)
    else $error("last byte did not start conversion");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt < IDX_W'(SCRATCH_BYTES))
    else $error("byte counter out of range");
  a_wait_on_stall: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK && out_valid && !out_ready |=> state == S_CHECK && out_valid)
    else $error("result overwrote pending beat");
  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out_valid && state == S_COLLECT)
    else $error("result load lost");
`endif
endmodule

// ----- hdl/otsc_dp.sv -----
module otsc_dp (
  input  logic                     clk,
  input  otsc_pkg::cmd_t           cmd,
  input  logic [7:0]               scratch_byte,
  input  logic [7:0]               family_code,
  output logic signed [otsc_pkg::TEMP_W-1:0] temperature,
  output logic [1:0]               status
);
  import otsc_pkg::*;

  // 1-wire crc-8, reflected poly 0x8c, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] c_in);
    logic [7:0] c;
    c = c_in;
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
    end
    return c;
  endfunction

  logic [7:0] crc;
  logic [7:0] temp_lo;
  logic [7:0] temp_hi;
  logic [7:0] res_byte;
  logic [7:0] remain_byte;
  logic [7:0] family;

  logic [7:0]  crc_base;
  logic [15:0] raw;
  logic [15:0] ext;
  logic [15:0] m0;
  logic [15:0] m_abs;
  logic [15:0] m_masked;

  logic [15:0] mag;
  logic        neg;
  logic        crc_bad;

  logic [15:0] whole;
  logic [13:0] frac_num;
  logic [15:0] sum;
  logic signed [16:0] t_next;
  logic signed [16:0] t;

  assign crc_base = (cmd.idx == '0) ? 8'h00 : crc;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      crc <= crc8_byte(crc_base ^ scratch_byte);
      if (cmd.idx == IDX_TEMP_LO) begin
        temp_lo <= scratch_byte;
        family  <= family_code;
      end
      if (cmd.idx == IDX_TEMP_HI) temp_hi <= scratch_byte;
      if (cmd.idx == IDX_CONFIG)  res_byte <= scratch_byte;
      if (cmd.idx == IDX_REMAIN)  remain_byte <= scratch_byte;
    end
  end

  // normalize: extended precision, sign magnitude, resolution mask
  always_comb begin
    raw      = {temp_hi, temp_lo};
    ext      = ({raw[15:1], 1'b0} << 3) + 16'd12 - {8'd0, remain_byte};
    m0       = (family == FAM_EXT) ? ext : raw;
    m_abs    = m0[15] ? (~m0 + 16'd1) : m0;
    m_masked = m_abs;
    if (family == FAM_RES_A || family == FAM_RES_B) begin
      unique case (res_byte[6:5])
        2'd0: m_masked = m_abs & 16'hFFF8;
        2'd1: m_masked = m_abs & 16'hFFFC;
        2'd2: m_masked = m_abs & 16'hFFFE;
        2'd3: m_masked = m_abs;
      endcase
    end
  end

  // scale sixteenths to tenths: whole*10 plus (fraction*640 + 512 if not negative)/1024
  always_comb begin
    whole    = {1'b0, mag[15:4], 3'b000} + {3'b000, mag[15:4], 1'b0};
    frac_num = {1'b0, mag[3:0], 9'd0} + {3'b000, mag[3:0], 7'd0}
             + (neg ? 14'd0 : 14'd512);
    sum      = whole + {12'd0, frac_num[13:10]};
    t_next   = neg ? -$signed({1'b0, sum}) : $signed({1'b0, sum});
  end

  always_ff @(posedge clk) begin
    if (cmd.norm) begin
      mag     <= m_masked;
      neg     <= m0[15];
      crc_bad <= (crc != 8'h00);
    end
    if (cmd.scale) t <= t_next;
    if (cmd.load) begin
      if (crc_bad) begin
        status      <= ST_CRC;
        temperature <= '0;
      end else if (t < T_MIN || t > T_MAX) begin
        status      <= ST_RANGE;
        temperature <= '0;
      end else begin
        status      <= ST_OK;
        temperature <= t[TEMP_W-1:0];
      end
    end
  end
endmodule

// ----- hdl/onewire_temp_scratchpad_convert_unit.sv -----
// one-wire thermometer scratchpad checker and decicelsius converter
//
// scratch (sink): one scratchpad byte per beat, byte 0 first; family_code is
// taken with byte 0. restart marks a beat as byte 0 and drops a partial
// scratchpad. after a result the next beat is byte 0 anyway.
// result (source): one beat per nine bytes, temperature in tenths of a degree
// and status (0 ok, 1 crc mismatch, 2 out of range, temperature 0 if nonzero).
// bytes are taken at one per cycle while collecting; the crc-8 advances a whole
// byte per beat. after the ninth byte the input stalls through the normalize,
// scale and range check steps; the result beat shows once the check step loads
// the output register.
// a finished result waits in the output register while the next scratchpad
// streams in; if it is still not taken when the next conversion is done, the
// block holds in the check step with scratch.ready low until result.ready.
// reset (rst, synchronous) empties the output register and sets the byte
// counter to byte 0.
module onewire_temp_scratchpad_convert_unit (
  input logic        clk,
  input logic        rst,
  otsc_in_if.sink    scratch,
  otsc_out_if.source result
);
  import otsc_pkg::*;

  cmd_t cmd;

  otsc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (scratch.valid),
    .in_restart (scratch.restart),
    .in_ready   (scratch.ready),
    .out_ready  (result.ready),
    .out_valid  (result.valid),
    .cmd        (cmd)
  );

  otsc_dp u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .scratch_byte (scratch.scratch_byte),
    .family_code  (scratch.family_code),
    .temperature  (result.temperature),
    .status       (result.status)
  );
endmodule

// ----- sim/otsc_tb_pkg.sv -----
package otsc_tb_pkg;
  import otsc_pkg::*;

  typedef struct {
    logic signed [TEMP_W-1:0] temperature;
    status_t                  status;
  } reading_t;

  class temp_scoreboard;
    logic [IDX_W-1:0] byte_idx;
    logic [7:0]       crc;
    logic [7:0]       temp_lo;
    logic [7:0]       temp_hi;
    logic [7:0]       res_cfg;
    logic [7:0]       remain;
    logic [7:0]       family;
    reading_t         pending_readings[$];
    int               errors;

    function new();
      byte_idx = '0;
      crc      = '0;
      temp_lo  = '0;
      temp_hi  = '0;
      res_cfg  = '0;
      remain   = '0;
      family   = '0;
      errors   = 0;
    endfunction

    // 1-wire crc-8, reflected poly 0x8c, one whole byte
    static function logic [7:0] crc8_step(logic [7:0] crc_in, logic [7:0] d);
      logic [7:0] c;
      int b;
      c = crc_in ^ d;
      for (b = 0; b < 8; b++)
        c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
      return c;
    endfunction

    function int to_decicelsius();
      logic [15:0] m;
      bit          neg;
      int          whole;
      int unsigned frac;
      m = {temp_hi, temp_lo};
      if (family == FAM_EXT) begin
        // half-degree reading refined by count-remain, 1/16 units
        m = (m & 16'hFFFE) << 3;
        m = m + 16'd12 - {8'h00, remain};
      end
      neg = m[15];
      if (neg) m = -m;
      if (family == FAM_RES_A || family == FAM_RES_B) begin
        case (res_cfg[6:5])
          2'd0: m[2:0] = '0;
          2'd1: m[1:0] = '0;
          2'd2: m[0] = 1'b0;
          default: ;
        endcase
      end
      whole = int'(m[15:4]) * 10;
      frac = m[3:0] * 640;
      if (!neg) frac += 512;
      frac /= 1024;
      whole += int'(frac);
      return neg ? -whole : whole;
    endfunction

    function void note_byte(logic [7:0] d, logic [7:0] fam, logic rs);
      logic [IDX_W-1:0] idx;
      reading_t         r;
      int               t;
      if (rs || byte_idx >= SCRATCH_BYTES) byte_idx = '0;
      idx = byte_idx;
      if (idx == IDX_TEMP_LO) begin
        crc = '0;
        family = fam;
      end
      crc = crc8_step(crc, d);
      case (idx)
        IDX_TEMP_LO: temp_lo = d;
        IDX_TEMP_HI: temp_hi = d;
        IDX_CONFIG:  res_cfg = d;
        IDX_REMAIN:  remain = d;
        default: ;
      endcase
      if (idx != LAST_IDX) begin
        byte_idx = idx + 1'b1;
        return;
      end
      byte_idx = '0;
      r.temperature = '0;
      r.status = ST_OK;
      if (crc != 8'h00) begin
        r.status = ST_CRC;
      end else begin
        t = to_decicelsius();
        if (t < T_MIN || t > T_MAX) r.status = ST_RANGE;
        else r.temperature = TEMP_W'(t);
      end
      pending_readings.push_back(r);
    endfunction

    function void check_result(logic signed [TEMP_W-1:0] t, logic [1:0] st);
      reading_t e;
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual temperature %0d status %0d",
                 $time, t, st);
        errors++;
        return;
      end
      e = pending_readings.pop_front();
      if (t !== e.temperature) begin
        $display("%0t: temperature mismatch, expected %0d actual %0d",
                 $time, e.temperature, t);
        errors++;
      end
      if (st !== e.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
    endfunction
  endclass

endpackage

// ----- sim/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import otsc_pkg::*;
  import otsc_tb_pkg::*;

  logic clk = 1'b0;
  logic rst;

  always #6 clk = ~clk;

  otsc_in_if  scratch_bus();
  otsc_out_if result_bus();

  onewire_temp_scratchpad_convert_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .scratch(scratch_bus),
    .result (result_bus)
  );

  temp_scoreboard board;
  int bytes_sent;
  int results_seen;
  bit tx_burst;
  bit rx_burst;

  task automatic send_byte(input logic [7:0] d, input logic [7:0] fam, input logic rs);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      scratch_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    scratch_bus.valid        <= 1'b1;
    scratch_bus.scratch_byte <= d;
    scratch_bus.family_code  <= fam;
    scratch_bus.restart      <= rs;
    do @(posedge clk); while (!scratch_bus.ready);
    board.note_byte(d, fam, rs);
    bytes_sent++;
  endtask

  // full scratchpad with a matching crc byte, optionally with one bit flipped
  task automatic send_pad(input logic [7:0] fam, input logic [15:0] raw,
                          input logic [7:0] cfg, input logic [7:0] remain,
                          input bit first_restart, input bit corrupt);
    logic [7:0] pad [SCRATCH_BYTES];
    logic [7:0] crc;
    int k;
    pad[0] = raw[7:0];
    pad[1] = raw[15:8];
    pad[2] = 8'($urandom);
    pad[3] = 8'($urandom);
    pad[4] = cfg;
    pad[5] = 8'($urandom);
    pad[6] = remain;
    pad[7] = 8'($urandom);
    crc = '0;
    for (k = 0; k < SCRATCH_BYTES - 1; k++) crc = temp_scoreboard::crc8_step(crc, pad[k]);
    pad[SCRATCH_BYTES-1] = crc;
    if (corrupt) begin
      k = $urandom_range(0, SCRATCH_BYTES - 1);
      pad[k] = pad[k] ^ (8'h01 << $urandom_range(0, 7));
    end
    tx_burst = ($urandom_range(0, 3) == 0);
    for (k = 0; k < SCRATCH_BYTES; k++)
      send_byte(pad[k], (k == 0) ? fam : 8'($urandom), (k == 0) ? first_restart : 1'b0);
  endtask

  // broken sequence that never reaches the last byte
  task automatic send_partial(input int n);
    int k;
    tx_burst = ($urandom_range(0, 1) == 0);
    for (k = 0; k < n; k++)
      send_byte(8'($urandom), 8'($urandom), (k == 0) || ($urandom_range(0, 7) == 0));
  endtask

  function automatic logic [7:0] pick_family();
    case ($urandom_range(0, 9))
      0, 1, 2: return FAM_EXT;
      3, 4, 5: return FAM_RES_A;
      6, 7:    return FAM_RES_B;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_raw(logic [7:0] fam);
    int v;
    case ($urandom_range(0, 4))
      0: v = int'($urandom);
      1: begin
        // around the range limits and the wrap points
        case ($urandom_range(0, 3))
          0: v = (fam == FAM_EXT) ? -110 : -880;
          1: v = (fam == FAM_EXT) ? 250 : 2000;
          2: v = 32'h8000;
          default: v = 32'h7FFF;
        endcase
        v = v + int'($urandom_range(0, 2)) - 1;
      end
      default: v = (fam == FAM_EXT) ? int'($urandom_range(0, 400)) - 140
                                    : int'($urandom_range(0, 3200)) - 1000;
    endcase
    return 16'(v);
  endfunction

  initial begin
    logic [7:0] fam;
    int kind;
    bit force_restart;
    board = new();
    bytes_sent = 0;
    tx_burst = 1'b0;
    rst <= 1'b1;
    scratch_bus.valid        <= 1'b0;
    scratch_bus.scratch_byte <= '0;
    scratch_bus.family_code  <= '0;
    scratch_bus.restart      <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // raw 0x8000 right after reset, no restart mark
    send_pad(FAM_RES_A, 16'h8000, 8'h7F, 8'h0C, 1'b0, 1'b0);
    // partial scratchpad dropped by a restart
    send_partial(3);
    send_pad(FAM_EXT, 16'h0032, 8'h3F, 8'h0C, 1'b1, 1'b0);
    // unknown family, crc and range errors together, no restart after a result
    send_pad(8'h55, 16'h7FFF, 8'hFF, 8'h00, 1'b0, 1'b1);

    force_restart = 1'b0;
    while (bytes_sent < 430) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        send_partial($urandom_range(1, 8));
        force_restart = 1'b1;
      end else begin
        fam = pick_family();
        send_pad(fam, pick_raw(fam), 8'($urandom),
                 ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 16)),
                 force_restart || ($urandom_range(0, 1) == 1), kind == 1);
        force_restart = 1'b0;
      end
    end
    scratch_bus.valid <= 1'b0;

    while (board.pending_readings.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    int gap;
    bit held_off;
    result_bus.ready <= 1'b0;
    results_seen = 0;
    held_off = 1'b0;
    rx_burst = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (results_seen == 6 && !held_off) begin
        // long hold so the output fills and the input side backs up
        held_off = 1'b1;
        result_bus.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        gap = rx_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
          result_bus.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!result_bus.valid);
      board.check_result(result_bus.temperature, result_bus.status);
      results_seen++;
      if ($urandom_range(0, 7) == 0) rx_burst = !rx_burst;
    end
  end

  initial begin
    #2_400_000;
    $display("simulation failed");
    $finish;
  end

endmodule
